// ===== rtl/core/stb_pkg.sv =====
// stb_pkg: shared types, sizes and codes for the timer bank
// depends on nothing; used by every rtl/core file

package stb_pkg;

	localparam int NUM_SLOTS          = 64;
	localparam int MAX_FIRES_PER_TICK = 64;

	localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
	localparam int FIRE_W = $clog2(MAX_FIRES_PER_TICK + 1);
	localparam int ID_W   = 31;
	localparam int TIME_W = 32;
	localparam int PER_W  = 20;

	localparam logic [PER_W-1:0] PERIOD_RESET = 20'd33333;

	localparam logic [1:0] OP_SET_ONCE = 2'd0;
	localparam logic [1:0] OP_SET_PER  = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;
	localparam logic [1:0] OP_TICK     = 2'd3;

	localparam logic [2:0] KIND_CREATED = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_CLEARED = 3'd2;
	localparam logic [2:0] KIND_FIRED   = 3'd3;
	localparam logic [2:0] KIND_NO_FIRE = 3'd4;

	typedef struct packed {
		logic              active;
		logic              periodic;
		logic [TIME_W-1:0] delay;
		logic [TIME_W-1:0] elapsed;
		logic [ID_W-1:0]   ident;
	} slot_t;

	typedef struct packed {
		logic shift;
		logic hold;
	} chain_ctl_t;

endpackage

// ===== rtl/core/stb_if.sv =====
// stb_if: valid/ready channels for requests and results
// depends on stb_pkg for field widths

interface stb_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                op;
	logic [stb_pkg::TIME_W-1:0] delay_us;
	logic [stb_pkg::ID_W-1:0]   timer_id;
	modport source (output valid, op, delay_us, timer_id, input ready);
	modport sink (input valid, op, delay_us, timer_id, output ready);
endinterface

interface stb_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               kind;
	logic [stb_pkg::ID_W-1:0] result_id;
	logic                     found;
	logic                     last;
	logic                     any_active;
	modport source (output valid, kind, result_id, found, last, any_active, input ready);
	modport sink (input valid, kind, result_id, found, last, any_active, output ready);
endinterface

// ===== rtl/core/stb_cell.sv =====
// stb_cell: one timer slot in the rotating chain
// depends on stb_pkg

module stb_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  stb_pkg::slot_t d,
	output stb_pkg::slot_t q
);

	logic                       active_q;
	stb_pkg::slot_t             data_q;

	// only the active flag needs reset, the rest is read while active
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (en) begin
			active_q <= d.active;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= d;
		end
	end

	always_comb begin
		q        = data_q;
		q.active = active_q;
	end

endmodule

// ===== rtl/core/stb_ctrl.sv =====
// stb_ctrl: sequencer working on the slot at the head of the chain
// depends on stb_pkg and stb_if

module stb_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	stb_req_if.sink                  req,
	stb_rsp_if.source                rsp,
	input  logic                     cfg_we,
	input  logic [stb_pkg::PER_W-1:0] cfg_wdata,
	input  stb_pkg::slot_t           head,
	output stb_pkg::slot_t           head_upd,
	output stb_pkg::chain_ctl_t      ctl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_END  = 2'd2;

	logic [1:0]                   state_q;
	logic [1:0]                   op_q;
	logic [stb_pkg::TIME_W-1:0]   delay_q;
	logic [stb_pkg::ID_W-1:0]     tid_q;
	logic [stb_pkg::IDX_W-1:0]    idx_q;
	logic                         added_q;
	logic                         found_q;
	logic [stb_pkg::ID_W-1:0]     res_id_q;
	logic [stb_pkg::FIRE_W-1:0]   fires_q;
	logic [stb_pkg::CNT_W-1:0]    cnt_q;
	logic [stb_pkg::ID_W-1:0]     next_id_q;
	logic [stb_pkg::PER_W-1:0]    period_q;
	logic                         pend_v_q;
	logic [stb_pkg::ID_W-1:0]     pend_id_q;
	logic                         pend_any_q;
	logic                         out_v_q;
	logic [2:0]                   out_kind_q;
	logic [stb_pkg::ID_W-1:0]     out_id_q;
	logic                         out_found_q;
	logic                         out_last_q;
	logic                         out_any_q;

	logic                         out_free;
	logic                         out_load;
	logic                         can_push;
	logic                         set_hit;
	logic                         clr_hit;
	logic                         fire;
	logic                         deact;
	logic [stb_pkg::TIME_W:0]     sum;
	logic [stb_pkg::CNT_W-1:0]    cnt_nxt;
	logic [stb_pkg::ID_W-1:0]     id_inc;
	logic                         idx_end;

	assign out_free = !out_v_q || rsp.ready;
	assign can_push = !pend_v_q || out_free;
	assign out_load = ((state_q == ST_RUN) && fire && pend_v_q) ||
		((state_q == ST_END) && out_free);
	assign sum      = {1'b0, head.elapsed} + {{(stb_pkg::TIME_W + 1 - stb_pkg::PER_W){1'b0}},
		period_q};
	assign idx_end  = (idx_q == stb_pkg::IDX_W'(stb_pkg::NUM_SLOTS - 1));
	assign id_inc   = next_id_q + 1'b1;

	always_comb begin
		head_upd  = head;
		ctl.shift = 1'b0;
		ctl.hold  = 1'b0;
		set_hit   = 1'b0;
		clr_hit   = 1'b0;
		fire      = 1'b0;
		if (state_q == ST_RUN) begin
			case (op_q)
				stb_pkg::OP_SET_ONCE, stb_pkg::OP_SET_PER: begin
					ctl.shift = 1'b1;
					if (!found_q && !head.active) begin
						set_hit           = 1'b1;
						head_upd.active   = 1'b1;
						head_upd.periodic = (op_q == stb_pkg::OP_SET_PER);
						head_upd.delay    = delay_q;
						head_upd.elapsed  = '0;
						head_upd.ident    = next_id_q;
					end
				end
				stb_pkg::OP_CLEAR: begin
					ctl.shift = 1'b1;
					if (!found_q && head.active && head.ident == tid_q) begin
						clr_hit         = 1'b1;
						head_upd.active = 1'b0;
					end
				end
				default: begin
					// add the frame period once, then fire this slot until it is not due or the tick's fire limit is reached
					if (head.active && !added_q) begin
						ctl.hold         = 1'b1;
						head_upd.elapsed = sum[stb_pkg::TIME_W] ? '1 : sum[stb_pkg::TIME_W-1:0];
					end else if (head.active && head.elapsed >= head.delay &&
						fires_q < stb_pkg::FIRE_W'(stb_pkg::MAX_FIRES_PER_TICK)) begin
						if (can_push) begin
							fire     = 1'b1;
							ctl.hold = 1'b1;
							if (head.periodic) begin
								head_upd.elapsed = head.elapsed - head.delay;
								head_upd.active  = (head.delay != '0);
							end else begin
								head_upd.active = 1'b0;
							end
						end
					end else begin
						ctl.shift = 1'b1;
					end
				end
			endcase
		end
		deact   = fire && !head_upd.active;
		cnt_nxt = cnt_q + stb_pkg::CNT_W'(set_hit) - stb_pkg::CNT_W'(clr_hit | deact);
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_v_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.result_id  = out_id_q;
	assign rsp.found      = out_found_q;
	assign rsp.last       = out_last_q;
	assign rsp.any_active = out_any_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			period_q  <= stb_pkg::PERIOD_RESET;
			next_id_q <= stb_pkg::ID_W'(1);
			cnt_q     <= '0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
			idx_q     <= '0;
			added_q   <= 1'b0;
			found_q   <= 1'b0;
			fires_q   <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			cnt_q <= cnt_nxt;
			if (rsp.ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_RUN;
						idx_q   <= '0;
						added_q <= 1'b0;
						found_q <= 1'b0;
						fires_q <= '0;
					end
				end
				ST_RUN: begin
					if (ctl.shift) begin
						added_q <= 1'b0;
						idx_q   <= idx_q + 1'b1;
						if (idx_end) begin
							state_q <= ST_END;
						end
					end else if (ctl.hold) begin
						added_q <= 1'b1;
					end
					if (set_hit) begin
						found_q   <= 1'b1;
						next_id_q <= (id_inc == '0) ? stb_pkg::ID_W'(1) : id_inc;
					end
					if (clr_hit) begin
						found_q <= 1'b1;
					end
					if (fire) begin
						fires_q  <= fires_q + 1'b1;
						pend_v_q <= 1'b1;
						// the previous fire is now known not to be the last
						if (pend_v_q) begin
							out_v_q     <= 1'b1;
							out_kind_q  <= stb_pkg::KIND_FIRED;
							out_id_q    <= pend_id_q;
							out_found_q <= 1'b0;
							out_last_q  <= 1'b0;
							out_any_q   <= pend_any_q;
						end
					end
				end
				ST_END: begin
					if (out_free) begin
						state_q    <= ST_IDLE;
						pend_v_q   <= 1'b0;
						out_v_q    <= 1'b1;
						out_last_q <= 1'b1;
						if (pend_v_q) begin
							out_kind_q  <= stb_pkg::KIND_FIRED;
							out_id_q    <= pend_id_q;
							out_found_q <= 1'b0;
							out_any_q   <= pend_any_q;
						end else begin
							out_any_q <= (cnt_q != '0);
							case (op_q)
								stb_pkg::OP_SET_ONCE, stb_pkg::OP_SET_PER: begin
									out_kind_q  <= found_q ? stb_pkg::KIND_CREATED :
										stb_pkg::KIND_FULL;
									out_id_q    <= found_q ? res_id_q : '0;
									out_found_q <= 1'b0;
								end
								stb_pkg::OP_CLEAR: begin
									out_kind_q  <= stb_pkg::KIND_CLEARED;
									out_id_q    <= '0;
									out_found_q <= found_q;
								end
								default: begin
									out_kind_q  <= stb_pkg::KIND_NO_FIRE;
									out_id_q    <= '0;
									out_found_q <= 1'b0;
								end
							endcase
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q    <= req.op;
			delay_q <= req.delay_us;
			tid_q   <= req.timer_id;
		end
		if (set_hit) begin
			res_id_q <= next_id_q;
		end
		if (fire) begin
			pend_id_q  <= head.ident;
			pend_any_q <= (cnt_nxt != '0);
		end
	end

endmodule

// ===== rtl/core/software_timer_bank_top.sv =====
// software_timer_bank_top: timer bank built as a rotating chain of slot cells
// depends on stb_pkg, stb_if, stb_cell and stb_ctrl
//
//  channel | dir | transfer
//  req     | in  | op, delay_us, timer_id
//  rsp     | out | kind, result_id, found, last, any_active
//  cfg     | in  | cfg_wdata written when cfg_we (frame_period_us)
//
// every request rotates the slot chain once past the head, one slot a cycle unless
// the head is held or stalled; a tick holds the head of each active slot for the
// period add and again for each fire
// stalls on rsp freeze the chain while a fire waits for space, and the final
// transfer of a request waits in the end state until the output is free
// arst_n clears the active flags and resets the id counter and the frame period

module software_timer_bank_top (
	input  logic                     clk,
	input  logic                     arst_n,
	stb_req_if.sink                  req,
	stb_rsp_if.source                rsp,
	input  logic                     cfg_we,
	input  logic [stb_pkg::PER_W-1:0] cfg_wdata
);

	stb_pkg::slot_t      slot_q [stb_pkg::NUM_SLOTS];
	stb_pkg::slot_t      head_upd;
	stb_pkg::chain_ctl_t ctl;

	stb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (slot_q[0]),
		.head_upd  (head_upd),
		.ctl       (ctl)
	);

	for (genvar i = 0; i < stb_pkg::NUM_SLOTS; i++) begin : g_cell
		stb_pkg::slot_t d;
		logic           en;
		if (i == 0) begin : g_head
			// head slot is rewritten in place while a tick works on it
			assign en = ctl.shift || ctl.hold;
			if (stb_pkg::NUM_SLOTS > 1) begin : g_more
				assign d = ctl.shift ? slot_q[1] : head_upd;
			end else begin : g_one
				assign d = head_upd;
			end
		end else if (i == stb_pkg::NUM_SLOTS - 1) begin : g_tail
			assign en = ctl.shift;
			assign d  = head_upd;
		end else begin : g_mid
			assign en = ctl.shift;
			assign d  = slot_q[i+1];
		end
		stb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (d),
			.q      (slot_q[i])
		);
	end

endmodule

// ===== rtl/core/stb_checker.sv =====
// stb_checker: port-level checks on the timer bank result channel
// depends on stb_pkg; bound to software_timer_bank_top

module stb_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [2:0]               rsp_kind,
	input logic [stb_pkg::ID_W-1:0] rsp_result_id,
	input logic                     rsp_found,
	input logic                     rsp_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_result_id))
		else $error("result changed while stalled");

	a_noid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == stb_pkg::KIND_FULL || rsp_kind == stb_pkg::KIND_CLEARED ||
		rsp_kind == stb_pkg::KIND_NO_FIRE) |-> rsp_result_id == '0)
		else $error("id on a result that carries none");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_kind == stb_pkg::KIND_CLEARED)
		else $error("found set outside clear");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == stb_pkg::KIND_CREATED || rsp_kind == stb_pkg::KIND_FULL ||
		rsp_kind == stb_pkg::KIND_CLEARED || rsp_kind == stb_pkg::KIND_NO_FIRE) |-> rsp_last)
		else $error("single result not marked last");

endmodule

bind software_timer_bank_top stb_checker u_stb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_kind      (rsp.kind),
	.rsp_result_id (rsp.result_id),
	.rsp_found     (rsp.found),
	.rsp_last      (rsp.last)
);
